// ----- rtl/pps_pkg.sv -----
package pps_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 8;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned SLOT_FW       = 3;
  localparam int unsigned PRIO_W        = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

endpackage

// ----- rtl/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler over NUM_SLOTS task slots. A load beat writes one slot; a tick
// beat picks the best ready slot (lowest priority value, then earliest arrival, then lowest
// slot), preempts the running task only for a strictly better priority or an equal priority
// with an earlier arrival, runs one time unit and reports completion times. Each beat returns
// exactly one result beat. A new beat is accepted only once the last one has been reported. A
// tick scans every slot, decides, runs the chosen task and, when that task finishes, computes
// turnaround and then waiting time before its report. A result beat that is not taken holds
// the block until it is. The slot scan reads one slot per cycle through the single shared
// compare/subtract unit that also computes response, turnaround and waiting times in later
// steps. Time saturates at its maximum value.
module preemptive_priority_scheduler #(
  parameter int unsigned NUM_SLOTS = pps_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [pps_pkg::SLOT_FW-1:0] slot_i,
  input  logic [pps_pkg::TIME_W-1:0]  arrival_i,
  input  logic [pps_pkg::TIME_W-1:0]  burst_i,
  input  logic [pps_pkg::PRIO_W-1:0]  prio_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        running_valid_o,
  output logic [pps_pkg::SLOT_FW-1:0] running_slot_o,
  output logic                        preempted_o,
  output logic                        first_run_o,
  output logic                        finished_o,
  output logic [pps_pkg::TIME_W-1:0]  turnaround_o,
  output logic [pps_pkg::TIME_W-1:0]  waiting_o,
  output logic [pps_pkg::TIME_W-1:0]  response_o,
  output logic [pps_pkg::TIME_W-1:0]  now_time_o,
  output logic                        all_done_o
);
  import pps_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RUN,
    S_TURN,
    S_WT,
    S_REPORT
  } state_e;

  state_e state_q;

  logic [TIME_W-1:0] arr_q   [NUM_SLOTS];
  logic [TIME_W-1:0] burst_q [NUM_SLOTS];
  logic [TIME_W-1:0] rem_q   [NUM_SLOTS];
  logic [TIME_W-1:0] resp_q  [NUM_SLOTS];
  logic [PRIO_W-1:0] prio_q  [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] loaded_q, done_q, started_q;

  logic              cur_valid_q;
  logic [SLOT_W-1:0] cur_slot_q;
  logic [TIME_W-1:0] time_q;

  logic [SLOT_W-1:0] idx_q;
  logic              best_valid_q;
  logic [SLOT_W-1:0] best_slot_q;
  logic [PRIO_W-1:0] best_prio_q;
  logic [TIME_W-1:0] best_arr_q;
  logic [PRIO_W-1:0] cur_prio_q;
  logic [TIME_W-1:0] cur_arr_q;

  logic              res_run_q, res_pre_q, res_first_q, res_fin_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [TIME_W-1:0] res_ta_q, res_wt_q, res_resp_q;

  logic              out_valid_q;

  logic [SLOT_W-1:0] rd_idx, ld_idx;
  logic [TIME_W-1:0] rd_arr, rd_burst, rd_rem, rd_resp;
  logic [PRIO_W-1:0] rd_prio;
  logic [TIME_W-1:0] alu_a, alu_b, alu_diff, time_inc;
  logic              alu_lt;
  logic              in_fire, ld_fire, run_fire, ready_slot, better, all_done;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ld_idx     = SLOT_W'(slot_i);
  assign ld_fire    = in_fire && (req_type_i == REQ_LOAD) && (32'(slot_i) < NUM_SLOTS);
  assign run_fire   = (state_q == S_RUN) && cur_valid_q;
  assign time_inc   = (time_q == '1) ? time_q : time_q + 1'b1;
  assign all_done   = ~|(loaded_q & ~done_q);

  always_comb begin
    rd_idx   = (state_q == S_SCAN) ? idx_q : cur_slot_q;
    rd_arr   = arr_q[rd_idx];
    rd_burst = burst_q[rd_idx];
    rd_rem   = rem_q[rd_idx];
    rd_resp  = resp_q[rd_idx];
    rd_prio  = prio_q[rd_idx];
  end

  always_comb begin
    unique case (state_q)
      S_SCAN: begin
        alu_a = rd_arr;
        alu_b = best_arr_q;
      end
      S_DECIDE: begin
        alu_a = best_arr_q;
        alu_b = cur_arr_q;
      end
      S_WT: begin
        alu_a = res_ta_q;
        alu_b = rd_burst;
      end
      default: begin
        alu_a = time_q;
        alu_b = rd_arr;
      end
    endcase
  end

  pps_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .lt_o   (alu_lt)
  );

  assign ready_slot = loaded_q[idx_q] && !done_q[idx_q] && (rd_arr <= time_q);
  assign better     = !best_valid_q || (rd_prio < best_prio_q) ||
                      ((rd_prio == best_prio_q) && alu_lt);

  always_ff @(posedge clk_i) begin
    if (ld_fire) begin
      arr_q[ld_idx]   <= arrival_i;
      burst_q[ld_idx] <= burst_i;
      rem_q[ld_idx]   <= burst_i;
      prio_q[ld_idx]  <= prio_i;
    end
    if (run_fire) begin
      rem_q[cur_slot_q] <= rd_rem - 1'b1;
      if (!started_q[cur_slot_q]) begin
        resp_q[cur_slot_q] <= alu_diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      loaded_q        <= '0;
      done_q          <= '0;
      started_q       <= '0;
      cur_valid_q     <= 1'b0;
      cur_slot_q      <= '0;
      time_q          <= '0;
      idx_q           <= '0;
      best_valid_q    <= 1'b0;
      best_slot_q     <= '0;
      best_prio_q     <= '0;
      best_arr_q      <= '0;
      cur_prio_q      <= '0;
      cur_arr_q       <= '0;
      res_run_q       <= 1'b0;
      res_pre_q       <= 1'b0;
      res_first_q     <= 1'b0;
      res_fin_q       <= 1'b0;
      res_slot_q      <= '0;
      res_ta_q        <= '0;
      res_wt_q        <= '0;
      res_resp_q      <= '0;
      out_valid_q     <= 1'b0;
      running_valid_o <= 1'b0;
      running_slot_o  <= '0;
      preempted_o     <= 1'b0;
      first_run_o     <= 1'b0;
      finished_o      <= 1'b0;
      turnaround_o    <= '0;
      waiting_o       <= '0;
      response_o      <= '0;
      now_time_o      <= '0;
      all_done_o      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_REPORT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_run_q    <= 1'b0;
            res_pre_q    <= 1'b0;
            res_first_q  <= 1'b0;
            res_fin_q    <= 1'b0;
            res_slot_q   <= '0;
            res_ta_q     <= '0;
            res_wt_q     <= '0;
            res_resp_q   <= '0;
            idx_q        <= '0;
            best_valid_q <= 1'b0;
            if (req_type_i == REQ_TICK) begin
              state_q <= S_SCAN;
            end else begin
              if (ld_fire) begin
                loaded_q[ld_idx]  <= 1'b1;
                done_q[ld_idx]    <= (burst_i == '0);
                started_q[ld_idx] <= 1'b0;
                if (cur_valid_q && (cur_slot_q == ld_idx)) begin
                  cur_valid_q <= 1'b0;
                end
              end
              state_q <= S_REPORT;
            end
          end
        end
        S_SCAN: begin
          if (ready_slot && better) begin
            best_valid_q <= 1'b1;
            best_slot_q  <= idx_q;
            best_prio_q  <= rd_prio;
            best_arr_q   <= rd_arr;
          end
          if (idx_q == cur_slot_q) begin
            cur_prio_q <= rd_prio;
            cur_arr_q  <= rd_arr;
          end
          if (idx_q == SLOT_W'(NUM_SLOTS - 1)) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DECIDE: begin
          if (best_valid_q) begin
            if (!cur_valid_q) begin
              cur_valid_q <= 1'b1;
              cur_slot_q  <= best_slot_q;
            end else if (best_prio_q < cur_prio_q) begin
              res_pre_q  <= 1'b1;
              cur_slot_q <= best_slot_q;
            end else if ((best_slot_q != cur_slot_q) && (best_prio_q == cur_prio_q) &&
                         alu_lt) begin
              cur_slot_q <= best_slot_q;
            end
          end
          state_q <= S_RUN;
        end
        S_RUN: begin
          time_q <= time_inc;
          if (cur_valid_q) begin
            res_run_q  <= 1'b1;
            res_slot_q <= cur_slot_q;
            if (!started_q[cur_slot_q]) begin
              started_q[cur_slot_q] <= 1'b1;
              res_first_q           <= 1'b1;
            end
            state_q <= (rd_rem == TIME_W'(1)) ? S_TURN : S_REPORT;
          end else begin
            state_q <= S_REPORT;
          end
        end
        S_TURN: begin
          res_ta_q            <= alu_diff;
          res_resp_q          <= rd_resp;
          res_fin_q           <= 1'b1;
          done_q[cur_slot_q]  <= 1'b1;
          cur_valid_q         <= 1'b0;
          state_q             <= S_WT;
        end
        S_WT: begin
          res_wt_q <= alu_diff;
          state_q  <= S_REPORT;
        end
        S_REPORT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            running_valid_o <= res_run_q;
            running_slot_o  <= SLOT_FW'(res_slot_q);
            preempted_o     <= res_pre_q;
            first_run_o     <= res_first_q;
            finished_o      <= res_fin_q;
            turnaround_o    <= res_ta_q;
            waiting_o       <= res_wt_q;
            response_o      <= res_resp_q;
            now_time_o      <= time_q;
            all_done_o      <= all_done;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_cur_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (loaded_q[cur_slot_q] && !done_q[cur_slot_q]))
    else $error("running slot is not a live task");

  a_done_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q & ~loaded_q) == '0)
    else $error("slot done without being loaded");

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q >= $past(time_q))
    else $error("time went backwards");

  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (finished_o || preempted_o || first_run_o)) |-> running_valid_o)
    else $error("task event reported on a beat where nothing ran");

  a_time_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q != $past(time_q)) |-> ($past(state_q) == S_RUN))
    else $error("time advanced outside the run step");

endmodule

// ----- rtl/pps_alu.sv -----
module pps_alu (
  input  logic [pps_pkg::TIME_W-1:0] a_i,
  input  logic [pps_pkg::TIME_W-1:0] b_i,
  output logic [pps_pkg::TIME_W-1:0] diff_o,
  output logic                       lt_o
);
  import pps_pkg::*;

  logic [TIME_W:0] sub;

  always_comb begin
    sub    = {1'b0, a_i} - {1'b0, b_i};
    lt_o   = sub[TIME_W];
    diff_o = sub[TIME_W] ? '0 : sub[TIME_W-1:0];
  end

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int unsigned NSLOT = NUM_SLOTS_DEF;

  typedef struct packed {
    logic              req;
    logic [SLOT_FW-1:0] slot;
    logic [TIME_W-1:0]  arrival;
    logic [TIME_W-1:0]  burst;
    logic [PRIO_W-1:0]  prio;
  } sched_req_t;

  typedef struct packed {
    logic               run_v;
    logic [SLOT_FW-1:0] run_slot;
    logic               preempted;
    logic               first_run;
    logic               finished;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  response;
    logic [TIME_W-1:0]  now_time;
    logic               all_done;
  } sched_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                req_type_i = REQ_LOAD;
  logic [SLOT_FW-1:0]  slot_i = '0;
  logic [TIME_W-1:0]   arrival_i = '0;
  logic [TIME_W-1:0]   burst_i = '0;
  logic [PRIO_W-1:0]   prio_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                running_valid_o;
  logic [SLOT_FW-1:0]  running_slot_o;
  logic                preempted_o;
  logic                first_run_o;
  logic                finished_o;
  logic [TIME_W-1:0]   turnaround_o;
  logic [TIME_W-1:0]   waiting_o;
  logic [TIME_W-1:0]   response_o;
  logic [TIME_W-1:0]   now_time_o;
  logic                all_done_o;

  preemptive_priority_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .slot_i          (slot_i),
    .arrival_i       (arrival_i),
    .burst_i         (burst_i),
    .prio_i          (prio_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .running_valid_o (running_valid_o),
    .running_slot_o  (running_slot_o),
    .preempted_o     (preempted_o),
    .first_run_o     (first_run_o),
    .finished_o      (finished_o),
    .turnaround_o    (turnaround_o),
    .waiting_o       (waiting_o),
    .response_o      (response_o),
    .now_time_o      (now_time_o),
    .all_done_o      (all_done_o)
  );

  always #5 clk_i = ~clk_i;

  sched_req_t    req_backlog[$];
  sched_report_t sched_reports[$];
  sched_req_t    on_bus;
  int            send_idle_pct = 19;
  int            recv_idle_pct = 69;
  int            mismatches = 0;
  int            beats_seen = 0;
  int            hold_left = 0;
  bit            hold_used = 1'b0;
  logic [TIME_W-1:0] gen_now = '0;

  logic [TIME_W-1:0] t_arr[NSLOT];
  logic [TIME_W-1:0] t_burst[NSLOT];
  logic [TIME_W-1:0] t_rem[NSLOT];
  logic [TIME_W-1:0] t_resp[NSLOT];
  logic [PRIO_W-1:0] t_prio[NSLOT];
  logic [NSLOT-1:0]  t_loaded = '0;
  logic [NSLOT-1:0]  t_done = '0;
  logic [NSLOT-1:0]  t_started = '0;
  logic              cur_v = 1'b0;
  logic [SLOT_FW-1:0] cur_slot = '0;
  logic [TIME_W-1:0] clk_now = '0;

  function automatic sched_report_t run_scheduler(sched_req_t r);
    sched_report_t      o;
    int                 best;
    logic [SLOT_FW-1:0] c;
    logic [TIME_W-1:0]  tat;
    o = '0;
    c = cur_slot;
    if (r.req == REQ_LOAD) begin
      t_arr[r.slot]     = r.arrival;
      t_burst[r.slot]   = r.burst;
      t_rem[r.slot]     = r.burst;
      t_prio[r.slot]    = r.prio;
      t_resp[r.slot]    = '0;
      t_loaded[r.slot]  = 1'b1;
      t_done[r.slot]    = (r.burst == '0);
      t_started[r.slot] = 1'b0;
      if (cur_v && cur_slot == r.slot) cur_v = 1'b0;
    end else begin
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (t_loaded[i] && !t_done[i] && t_rem[i] != '0 && t_arr[i] <= clk_now) begin
          if (best < 0 || t_prio[i] < t_prio[best] ||
              (t_prio[i] == t_prio[best] && t_arr[i] < t_arr[best])) best = i;
        end
      end
      if (best >= 0) begin
        if (!cur_v) begin
          cur_v = 1'b1;
          cur_slot = SLOT_FW'(best);
        end else if (t_prio[best] < t_prio[cur_slot]) begin
          o.preempted = 1'b1;
          cur_slot = SLOT_FW'(best);
        end else if (best != cur_slot && t_prio[best] == t_prio[cur_slot] &&
                     t_arr[best] < t_arr[cur_slot]) begin
          cur_slot = SLOT_FW'(best);
        end
      end
      c = cur_slot;
      if (cur_v) begin
        o.run_v = 1'b1;
        o.run_slot = c;
        if (!t_started[c]) begin
          t_resp[c] = (clk_now >= t_arr[c]) ? clk_now - t_arr[c] : '0;
          t_started[c] = 1'b1;
          o.first_run = 1'b1;
        end
        if (t_rem[c] != '0) t_rem[c] = t_rem[c] - 1'b1;
      end
      if (clk_now != '1) clk_now = clk_now + 1'b1;
      if (cur_v && t_rem[c] == '0) begin
        tat = (clk_now >= t_arr[c]) ? clk_now - t_arr[c] : '0;
        t_done[c] = 1'b1;
        o.finished = 1'b1;
        o.turnaround = tat;
        o.waiting = (tat >= t_burst[c]) ? tat - t_burst[c] : '0;
        o.response = t_resp[c];
        cur_v = 1'b0;
      end
    end
    o.now_time = clk_now;
    o.all_done = ((t_loaded & ~t_done) == '0);
    return o;
  endfunction

  function automatic void note_field(string name, logic [TIME_W-1:0] want,
                                     logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) sched_reports.push_back(run_scheduler(on_bus));
      if (!in_valid_i || in_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = req_backlog.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= on_bus.req;
          slot_i     <= on_bus.slot;
          arrival_i  <= on_bus.arrival;
          burst_i    <= on_bus.burst;
          prio_i     <= on_bus.prio;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    sched_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        if (sched_reports.size() == 0) begin
          $display("%0t result beat with no request pending", $time);
          mismatches++;
        end else begin
          want = sched_reports.pop_front();
          note_field("running_valid", want.run_v, running_valid_o);
          note_field("running_slot", want.run_slot, running_slot_o);
          note_field("preempted", want.preempted, preempted_o);
          note_field("first_run", want.first_run, first_run_o);
          note_field("finished", want.finished, finished_o);
          note_field("turnaround", want.turnaround, turnaround_o);
          note_field("waiting", want.waiting, waiting_o);
          note_field("response", want.response, response_o);
          note_field("now_time", want.now_time, now_time_o);
          note_field("all_done", want.all_done, all_done_o);
        end
      end
      if (!hold_used && beats_seen >= 30) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_load(int s, int a, int b, int p);
    sched_req_t r;
    r.req = REQ_LOAD;
    r.slot = SLOT_FW'(s);
    r.arrival = TIME_W'(a);
    r.burst = TIME_W'(b);
    r.prio = PRIO_W'(p);
    req_backlog.push_back(r);
  endtask

  task automatic push_tick();
    sched_req_t r;
    r.req = REQ_TICK;
    r.slot = SLOT_FW'($urandom);
    r.arrival = TIME_W'($urandom);
    r.burst = TIME_W'($urandom);
    r.prio = PRIO_W'($urandom);
    req_backlog.push_back(r);
    if (gen_now != '1) gen_now = gen_now + 1'b1;
  endtask

  task automatic random_beat();
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    int                m;
    if ($urandom_range(99) < 35) begin
      m = $urandom_range(99);
      if (m < 75) a = TIME_W'(gen_now + $urandom_range(12));
      else if (m < 90) a = (gen_now > 5) ? TIME_W'(gen_now - $urandom_range(5)) : '0;
      else a = TIME_W'($urandom);
      m = $urandom_range(99);
      if (m < 4) b = '0;
      else if (m < 8) b = TIME_W'($urandom);
      else b = TIME_W'($urandom_range(6, 1));
      push_load(int'($urandom_range(NSLOT - 1)), int'(a), int'(b), int'($urandom_range(7)));
    end else begin
      push_tick();
    end
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || in_valid_i || sched_reports.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_tick();
    push_load(0, 0, 3, 5);
    push_load(7, 2, 1, 7);
    push_load(1, 0, 0, 0);
    push_tick();
    push_tick();
    push_load(3, 0, 2, 0);
    push_tick();
    push_tick();
    push_tick();
    push_load(5, 5, 4, 2);
    push_tick();
    push_load(6, 1, 1, 2);
    push_tick();
    push_load(4, 8, 65535, 1);
    push_tick();
    push_load(4, 3, 1, 1);
    repeat (6) push_tick();
    repeat (200) random_beat();
    drain();

    send_idle_pct = 69;
    recv_idle_pct = 19;
    repeat (200) random_beat();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_load(0, int'(gen_now), 0, 3);
    push_load(2, int'(gen_now), 3, 0);
    repeat (25) random_beat();
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && sched_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
